// ===== rtl/core/edit_distance_engine_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef EDIT_DISTANCE_ENGINE_MACROS_SVH
`define EDIT_DISTANCE_ENGINE_MACROS_SVH

// Clocked assertion, masked while reset is held.
`define EDE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also watches reset cycles.
`define EDE_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/ede_pkg.sv =====
`timescale 1ns / 1ps

package ede_pkg;

    localparam int MAX_LEN  = 64;
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int ADDR_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    // one spare bit so cost + 1 never wraps
    localparam int COST_W   = LEN_W + 1;
    localparam int CHAR_W   = 16;
    localparam int DIST_W   = 7;
    localparam int DIST_MAX = (2 ** DIST_W) - 1;

    localparam int REG_SUBSTRING_MODE = 0;

    typedef enum logic [1:0] {
        OP_APPEND_A = 2'd0,
        OP_APPEND_B = 2'd1,
        OP_COMPUTE  = 2'd2,
        OP_NOP      = 2'd3
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] char_code;
    } t_in_item;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW,
        ST_CELL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic append_a;
        logic append_b;
        logic init_start;
        logic init_wr;
        logic row_start;
        logic calc;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic a_empty;
        logic b_empty;
        logic init_last;
        logic cell_last;
        logic row_last;
        logic out_busy;
    } t_stat;

endpackage

// ===== rtl/core/edit_distance_engine.sv =====
`timescale 1ns / 1ps

// Levenshtein edit distance between two strings of 16-bit code units, each
// up to 64 units long. Op 0 appends char_code to the first string, op 1 to
// the second, op 3 does nothing; none of these ops gives any
// result. Appends beyond 64 units are dropped and flagged in the next result.
// Op 2 computes, returns {distance, overflow} and clears both strings. With
// substring_mode (register 0) set, the result is the best match of the second
// string anywhere inside the first. A compute steps the controller through
// INIT, then ROW and CELL for each row of the table, then DONE; with either
// string empty it goes from INIT straight to DONE. The result is valid, and
// input is taken again, once it is back in IDLE. The table is walked one
// cell per cycle through a single in-place row memory with a registered read.
// A new compute is held off until the previous result has been transferred;
// appends are taken meanwhile. No memory clearing pass follows reset.
module edit_distance_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ede_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ede_pkg::t_out_item  o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic           r_substring_mode;
    logic           w_reg_hit;
    ede_pkg::t_cmd  w_cmd;
    ede_pkg::t_stat w_stat;

    assign pready    = 1'b1;
    assign w_reg_hit = (paddr[2] == 1'(ede_pkg::REG_SUBSTRING_MODE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_substring_mode <= 1'b0;
        end else if (psel && penable && pwrite && pready && w_reg_hit) begin
            r_substring_mode <= pwdata[0];
        end
    end

    assign prdata = w_reg_hit ? {31'b0, r_substring_mode} : 32'b0;

    ede_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_data.op),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ede_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_char_code      (i_in_data.char_code),
        .i_substring_mode (r_substring_mode),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_data       (o_out_data)
    );

endmodule

// ===== rtl/core/ede_ctrl.sv =====
`timescale 1ns / 1ps

module ede_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  ede_pkg::t_op     i_op,
    output logic             o_in_ready,
    input  ede_pkg::t_stat   i_stat,
    output ede_pkg::t_cmd    o_cmd
);

    ede_pkg::t_state r_state;
    ede_pkg::t_state n_state;
    logic            w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ede_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        w_accept   = 1'b0;
        unique case (r_state)
            ede_pkg::ST_IDLE: begin
                // a compute waits until the previous result has been taken
                o_in_ready = !(i_op == ede_pkg::OP_COMPUTE && i_stat.out_busy);
                w_accept   = i_in_valid && o_in_ready;
                if (w_accept) begin
                    unique case (i_op)
                        ede_pkg::OP_APPEND_A: o_cmd.append_a = 1'b1;
                        ede_pkg::OP_APPEND_B: o_cmd.append_b = 1'b1;
                        ede_pkg::OP_COMPUTE: begin
                            o_cmd.init_start = 1'b1;
                            n_state          = ede_pkg::ST_INIT;
                        end
                        ede_pkg::OP_NOP: ;
                        default: ;
                    endcase
                end
            end
            ede_pkg::ST_INIT: begin
                if (i_stat.b_empty || i_stat.a_empty) begin
                    n_state = ede_pkg::ST_DONE;
                end else begin
                    o_cmd.init_wr = 1'b1;
                    if (i_stat.init_last) begin
                        n_state = ede_pkg::ST_ROW;
                    end
                end
            end
            ede_pkg::ST_ROW: begin
                o_cmd.row_start = 1'b1;
                n_state         = ede_pkg::ST_CELL;
            end
            ede_pkg::ST_CELL: begin
                o_cmd.calc = 1'b1;
                if (i_stat.cell_last) begin
                    n_state = i_stat.row_last ? ede_pkg::ST_DONE : ede_pkg::ST_ROW;
                end
            end
            ede_pkg::ST_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = ede_pkg::ST_IDLE;
            end
            default: n_state = ede_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/ede_dp.sv =====
`timescale 1ns / 1ps

module ede_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ede_pkg::CHAR_W-1:0]    i_char_code,
    input  logic                          i_substring_mode,
    input  ede_pkg::t_cmd                 i_cmd,
    output ede_pkg::t_stat                o_stat,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ede_pkg::t_out_item            o_out_data
);

    localparam int LW = ede_pkg::LEN_W;
    localparam int AW = ede_pkg::ADDR_W;
    localparam int CW = ede_pkg::COST_W;

    logic [ede_pkg::CHAR_W-1:0] mem_a   [ede_pkg::MAX_LEN];
    logic [ede_pkg::CHAR_W-1:0] mem_b   [ede_pkg::MAX_LEN];
    // holds row columns 1..n at index column-1, updated in place
    logic [CW-1:0]              mem_row [ede_pkg::MAX_LEN];

    logic [LW-1:0]              r_len_a;
    logic [LW-1:0]              r_len_b;
    logic                       r_drop;
    logic [LW-1:0]              r_i;
    logic [LW-1:0]              r_j;
    logic [CW-1:0]              r_diag;
    logic [CW-1:0]              r_left;
    logic [CW-1:0]              r_best;
    logic [CW-1:0]              r_last;
    logic [ede_pkg::CHAR_W-1:0] r_ca;
    logic [ede_pkg::CHAR_W-1:0] r_cb;
    logic [CW-1:0]              r_up;
    logic                       r_out_valid;
    ede_pkg::t_out_item         r_out;

    logic [LW-1:0]              w_i_next;
    logic [LW-1:0]              w_j_next;
    logic                       w_rd_en;
    logic [AW-1:0]              w_rd_addr;
    logic [CW-1:0]              w_del;
    logic [CW-1:0]              w_ins;
    logic [CW-1:0]              w_rep;
    logic [CW-1:0]              w_val;
    logic [CW-1:0]              w_result;
    logic [31:0]                w_result_ext;
    logic                       w_a_full;
    logic                       w_b_full;

    assign w_i_next = r_i + LW'(1);
    assign w_j_next = r_j + LW'(1);
    assign w_a_full = (r_len_a == LW'(ede_pkg::MAX_LEN));
    assign w_b_full = (r_len_b == LW'(ede_pkg::MAX_LEN));

    assign o_stat.a_empty   = (r_len_a == '0);
    assign o_stat.b_empty   = (r_len_b == '0);
    assign o_stat.init_last = (w_j_next == r_len_b);
    assign o_stat.cell_last = (w_j_next == r_len_b);
    assign o_stat.row_last  = (w_i_next == r_len_a);
    assign o_stat.out_busy  = r_out_valid;

    // row read for the next cell is issued while the current cell is written
    assign w_rd_en   = i_cmd.row_start || (i_cmd.calc && !o_stat.cell_last);
    assign w_rd_addr = i_cmd.row_start ? '0 : w_j_next[AW-1:0];

    always_comb begin
        w_del = r_up + CW'(1);
        w_ins = r_left + CW'(1);
        w_rep = r_diag + CW'(r_ca != r_cb);
        w_val = w_del;
        if (w_ins < w_val) begin
            w_val = w_ins;
        end
        if (w_rep < w_val) begin
            w_val = w_rep;
        end
    end

    assign w_result     = i_substring_mode ? r_best : r_last;
    assign w_result_ext = 32'(w_result);

    // string and row memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.append_a && !w_a_full) begin
            mem_a[r_len_a[AW-1:0]] <= i_char_code;
        end
        if (i_cmd.append_b && !w_b_full) begin
            mem_b[r_len_b[AW-1:0]] <= i_char_code;
        end
        if (i_cmd.init_wr) begin
            mem_row[r_j[AW-1:0]] <= CW'(w_j_next);
        end else if (i_cmd.calc) begin
            mem_row[r_j[AW-1:0]] <= w_val;
        end
        if (i_cmd.row_start) begin
            r_ca <= mem_a[r_i[AW-1:0]];
        end
        if (w_rd_en) begin
            r_cb <= mem_b[w_rd_addr];
            r_up <= mem_row[w_rd_addr];
        end
    end

    // working registers of the table walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.init_start) begin
            r_i    <= '0;
            r_j    <= '0;
            r_best <= CW'(r_len_b);
            r_last <= (r_len_b == '0) ? CW'(r_len_a) : CW'(r_len_b);
        end
        if (i_cmd.init_wr) begin
            r_j <= w_j_next;
        end
        if (i_cmd.row_start) begin
            r_j    <= '0;
            r_diag <= i_substring_mode ? '0 : CW'(r_i);
            r_left <= i_substring_mode ? '0 : CW'(w_i_next);
        end
        if (i_cmd.calc) begin
            r_j    <= w_j_next;
            r_diag <= r_up;
            r_left <= w_val;
            if (o_stat.cell_last) begin
                r_i    <= w_i_next;
                r_last <= w_val;
                if (w_val < r_best) begin
                    r_best <= w_val;
                end
            end
        end
        if (i_cmd.finish) begin
            r_out.distance <= (w_result_ext > 32'(ede_pkg::DIST_MAX))
                              ? ede_pkg::DIST_W'(ede_pkg::DIST_MAX)
                              : w_result_ext[ede_pkg::DIST_W-1:0];
            r_out.overflow <= r_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_a     <= '0;
            r_len_b     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.append_a) begin
                if (w_a_full) begin
                    r_drop <= 1'b1;
                end else begin
                    r_len_a <= r_len_a + LW'(1);
                end
            end
            if (i_cmd.append_b) begin
                if (w_b_full) begin
                    r_drop <= 1'b1;
                end else begin
                    r_len_b <= r_len_b + LW'(1);
                end
            end
            if (i_cmd.finish) begin
                r_len_a     <= '0;
                r_len_b     <= '0;
                r_drop      <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/core/ede_checker.sv =====
`timescale 1ns / 1ps
`include "edit_distance_engine_macros.svh"

module ede_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input ede_pkg::t_in_item   i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input ede_pkg::t_out_item  o_out_data
);

    `EDE_ASSERT_RST(a_rst_no_result, !i_rst_n |=> !o_out_valid, "result valid after reset")

    `EDE_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "result dropped or changed while stalled")

    `EDE_ASSERT(a_no_compute_pending, o_out_valid && !i_out_ready |-> !(i_in_valid && o_in_ready && i_in_data.op == ede_pkg::OP_COMPUTE), "compute taken over a pending result")

    `EDE_ASSERT(a_dist_range, o_out_valid |-> 32'(o_out_data.distance) <= ede_pkg::MAX_LEN, "distance above string length limit")

endmodule

bind edit_distance_engine ede_checker u_ede_checker (.*);

// ===== tb/sv/tb_edit_distance_engine.sv =====
`timescale 1ns / 1ps

module tb_edit_distance_engine;

    localparam int MAX_LEN  = ede_pkg::MAX_LEN;
    localparam int CHAR_W   = ede_pkg::CHAR_W;
    localparam int DIST_W   = ede_pkg::DIST_W;
    localparam int DIST_MAX = ede_pkg::DIST_MAX;

    localparam int STALL_LIMIT      = 25000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 8;
    localparam int TAIL_CYCLES      = 50;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    ede_pkg::t_in_item  i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    ede_pkg::t_out_item o_out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // shadow of the block's strings and register
    logic [CHAR_W-1:0]  str_a [MAX_LEN];
    logic [CHAR_W-1:0]  str_b [MAX_LEN];
    int                 len_first;
    int                 len_second;
    bit                 chars_dropped;
    bit                 substring_on;

    ede_pkg::t_out_item expected_distances[$];
    ede_pkg::t_out_item want_item;
    int                 error_count;
    int                 items_sent;
    int                 quiet_cycles;
    bit                 in_idle_on;
    bit                 out_idle_on;
    bit                 long_hold_req;

    edit_distance_engine u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // two-row Levenshtein table over the shadow strings
    function automatic ede_pkg::t_out_item predict_distance();
        int unsigned        prev_row [MAX_LEN + 1];
        int unsigned        cur_row [MAX_LEN + 1];
        int unsigned        best;
        int unsigned        del_c;
        int unsigned        ins_c;
        int unsigned        rep_c;
        int unsigned        d;
        ede_pkg::t_out_item r;
        for (int j = 0; j <= MAX_LEN; j++) begin
            prev_row[j] = j;
            cur_row[j]  = 0;
        end
        best = len_second;
        for (int i = 0; i < len_first; i++) begin
            cur_row[0] = substring_on ? 0 : i + 1;
            for (int j = 0; j < len_second; j++) begin
                del_c = prev_row[j + 1] + 1;
                ins_c = cur_row[j] + 1;
                rep_c = prev_row[j] + ((str_a[i] != str_b[j]) ? 1 : 0);
                cur_row[j + 1] = (del_c < ins_c) ? del_c : ins_c;
                if (rep_c < cur_row[j + 1])
                    cur_row[j + 1] = rep_c;
            end
            prev_row = cur_row;
            if (prev_row[len_second] < best)
                best = prev_row[len_second];
        end
        d = substring_on ? best : prev_row[len_second];
        if (d > DIST_MAX)
            d = DIST_MAX;
        r.distance = DIST_W'(d);
        r.overflow = chars_dropped;
        return r;
    endfunction

    function automatic void track_item(input ede_pkg::t_op op,
                                       input logic [CHAR_W-1:0] code);
        case (op)
            ede_pkg::OP_APPEND_A: begin
                if (len_first < MAX_LEN) begin
                    str_a[len_first] = code;
                    len_first++;
                end else begin
                    chars_dropped = 1'b1;
                end
            end
            ede_pkg::OP_APPEND_B: begin
                if (len_second < MAX_LEN) begin
                    str_b[len_second] = code;
                    len_second++;
                end else begin
                    chars_dropped = 1'b1;
                end
            end
            ede_pkg::OP_COMPUTE: begin
                expected_distances = {expected_distances, predict_distance()};
                len_first     = 0;
                len_second    = 0;
                chars_dropped = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // valid is left high after a transfer; it drops only before a gap or a drain
    task automatic send_item(input ede_pkg::t_op op, input logic [CHAR_W-1:0] code);
        ede_pkg::t_in_item item;
        item.op        = op;
        item.char_code = code;
        if (in_idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        track_item(op, code);
        if (op != ede_pkg::OP_NOP)
            items_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_distances.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_substring_mode(input bit mode);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(ede_pkg::REG_SUBSTRING_MODE * 4);
        pwdata  <= 32'(mode);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        substring_on = mode;
    endtask

    function automatic logic [CHAR_W-1:0] draw_char(input bit narrow,
                                                   input logic [CHAR_W-1:0] base);
        if (narrow)
            return base + CHAR_W'($urandom_range(0, 3));
        return CHAR_W'($urandom);
    endfunction

    // one load of both strings in random interleave, normally closed by a compute
    task automatic send_random_pair();
        logic [CHAR_W-1:0] a_chars[$];
        logic [CHAR_W-1:0] b_chars[$];
        logic [CHAR_W-1:0] base;
        int                n_a;
        int                n_b;
        int                pick;
        int                start;
        bit                narrow;
        pick = $urandom_range(0, 39);
        if (pick == 0) begin
            n_a = $urandom_range(MAX_LEN - 2, MAX_LEN + 3);
            n_b = $urandom_range(MAX_LEN - 8, MAX_LEN + 3);
        end else if (pick <= 2) begin
            n_a = $urandom_range(0, MAX_LEN);
            n_b = $urandom_range(0, 20);
        end else begin
            n_a = $urandom_range(0, 10);
            n_b = $urandom_range(0, 6);
        end
        narrow = ($urandom_range(0, 3) != 0);
        base   = CHAR_W'($urandom);
        for (int k = 0; k < n_a; k++)
            a_chars = {a_chars, draw_char(narrow, base)};
        if (n_b > 0 && n_b <= n_a && $urandom_range(0, 2) == 0) begin
            // second string cut from the first, maybe with one edit
            start = $urandom_range(0, n_a - n_b);
            for (int k = 0; k < n_b; k++)
                b_chars = {b_chars, a_chars[start + k]};
            if ($urandom_range(0, 1) == 0)
                b_chars[$urandom_range(0, n_b - 1)] = draw_char(narrow, base);
        end else begin
            for (int k = 0; k < n_b; k++)
                b_chars = {b_chars, draw_char(narrow, base)};
        end
        while (a_chars.size() + b_chars.size() > 0) begin
            if ($urandom_range(0, 19) == 0)
                send_item(ede_pkg::OP_NOP, CHAR_W'($urandom));
            else if (b_chars.size() == 0 ||
                     (a_chars.size() != 0 && $urandom_range(0, 1) == 0))
                send_item(ede_pkg::OP_APPEND_A, a_chars.pop_front());
            else
                send_item(ede_pkg::OP_APPEND_B, b_chars.pop_front());
        end
        // now and then strings carry over, or a second compute sees empty strings
        if ($urandom_range(0, 15) != 0)
            send_item(ede_pkg::OP_COMPUTE, CHAR_W'($urandom));
        if ($urandom_range(0, 15) == 0)
            send_item(ede_pkg::OP_COMPUTE, CHAR_W'($urandom));
    endtask

    task automatic test_full_mode_edges();
        set_substring_mode(1'b0);
        send_item(ede_pkg::OP_COMPUTE, 16'h0000);
        send_item(ede_pkg::OP_APPEND_A, 16'h0000);
        send_item(ede_pkg::OP_APPEND_A, 16'hFFFF);
        send_item(ede_pkg::OP_COMPUTE, 16'hFFFF);
        send_item(ede_pkg::OP_APPEND_B, 16'hFFFF);
        send_item(ede_pkg::OP_APPEND_B, 16'h0000);
        send_item(ede_pkg::OP_COMPUTE, 16'h0000);
        send_item(ede_pkg::OP_APPEND_A, 16'h0061);
        send_item(ede_pkg::OP_APPEND_A, 16'h0062);
        send_item(ede_pkg::OP_APPEND_B, 16'h0062);
        send_item(ede_pkg::OP_NOP, 16'hFFFF);
        send_item(ede_pkg::OP_APPEND_B, 16'h0061);
        send_item(ede_pkg::OP_COMPUTE, 16'h5A5A);
    endtask

    task automatic test_substring_edges();
        set_substring_mode(1'b1);
        send_item(ede_pkg::OP_APPEND_A, 16'h0078);
        send_item(ede_pkg::OP_APPEND_A, 16'h0061);
        send_item(ede_pkg::OP_APPEND_A, 16'h0062);
        send_item(ede_pkg::OP_APPEND_A, 16'h0079);
        send_item(ede_pkg::OP_APPEND_B, 16'h0061);
        send_item(ede_pkg::OP_APPEND_B, 16'h0062);
        send_item(ede_pkg::OP_COMPUTE, 16'h0000);
        // empty first string
        send_item(ede_pkg::OP_APPEND_B, 16'h0061);
        send_item(ede_pkg::OP_APPEND_B, 16'h0062);
        send_item(ede_pkg::OP_COMPUTE, 16'h0000);
        // empty second string
        send_item(ede_pkg::OP_APPEND_A, 16'h0061);
        send_item(ede_pkg::OP_APPEND_A, 16'h0062);
        send_item(ede_pkg::OP_COMPUTE, 16'hFFFF);
    endtask

    task automatic test_full_strings();
        set_substring_mode(1'b0);
        for (int k = 0; k < MAX_LEN; k++)
            send_item(ede_pkg::OP_APPEND_A, CHAR_W'($urandom));
        send_item(ede_pkg::OP_COMPUTE, 16'h0000);
        // disjoint alphabets, both strings pushed past the end
        for (int k = 0; k < MAX_LEN + 2; k++)
            send_item(ede_pkg::OP_APPEND_A, 16'h4000 | CHAR_W'($urandom_range(0, 255)));
        for (int k = 0; k < MAX_LEN + 1; k++)
            send_item(ede_pkg::OP_APPEND_B, 16'h8000 | CHAR_W'($urandom_range(0, 255)));
        send_item(ede_pkg::OP_COMPUTE, 16'h0000);
    endtask

    // result held back long enough that the next compute backs up the input
    task automatic test_backpressure();
        set_substring_mode(1'b1);
        long_hold_req = 1'b1;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 4; k++) begin
                send_item(ede_pkg::OP_APPEND_A, CHAR_W'($urandom_range(0, 3)));
                send_item(ede_pkg::OP_APPEND_B, CHAR_W'($urandom_range(0, 3)));
            end
            send_item(ede_pkg::OP_COMPUTE, 16'h0000);
        end
    endtask

    task automatic run_random_phase(input bit mode, input int n_items);
        int stop_at;
        set_substring_mode(mode);
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
            send_random_pair();
    endtask

    task automatic test_random_mix();
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        run_random_phase(1'b1, 300);
        run_random_phase(1'b0, 300);
        wait_idle();
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        run_random_phase(1'b1, 150);
    endtask

    initial begin
        in_idle_on    = 1'b1;
        out_idle_on   = 1'b1;
        long_hold_req = 1'b0;
        error_count   = 0;
        items_sent    = 0;
        len_first     = 0;
        len_second    = 0;
        chars_dropped = 1'b0;
        substring_on  = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_full_mode_edges();
        test_substring_edges();
        test_full_strings();
        test_backpressure();
        test_random_mix();
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // result side: short random stalls, plus one long hold on request
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end else if (out_idle_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(0, 15)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_distances.size() == 0) begin
                $error("result transfer with nothing expected: distance %0d overflow %0d",
                       o_out_data.distance, o_out_data.overflow);
                error_count++;
            end else begin
                want_item = expected_distances.pop_front();
                if (o_out_data.distance !== want_item.distance) begin
                    $error("distance: expected %0d, got %0d",
                           want_item.distance, o_out_data.distance);
                    error_count++;
                end
                if (o_out_data.overflow !== want_item.overflow) begin
                    $error("overflow: expected %0d, got %0d",
                           want_item.overflow, o_out_data.overflow);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $error("no transfer for %0d cycles", quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial quiet_cycles = 0;

endmodule
